// File: hw/rtl/necir_pkg.sv
// Shared types, codes and reset values for the NEC IR frame decoder.
package necir_pkg;

  localparam int unsigned PeriodW   = 16;
  localparam int unsigned TolW      = 12;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FrameBits = 32;
  localparam int unsigned CountW    = $clog2(FrameBits);
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam logic [PeriodW-1:0] HeaderCenterRst = 16'd13500;
  localparam logic [TolW-1:0]    HeaderTolRst    = 12'd500;
  localparam logic [PeriodW-1:0] BitThreshRst    = 16'd1650;
  localparam logic [PeriodW-1:0] RepeatMinRst    = 16'd12500;
  localparam logic [PeriodW-1:0] RepeatMaxRst    = 16'd13000;

  typedef enum logic [2:0] {
    REG_HEADER_CENTER = 3'd0,
    REG_HEADER_TOL    = 3'd1,
    REG_BIT_THRESH    = 3'd2,
    REG_REPEAT_MIN    = 3'd3,
    REG_REPEAT_MAX    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BITS = 2'd1,
    PH_GOOD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_FRAME  = 2'd0,
    EV_REPEAT = 2'd1,
    EV_ERROR  = 2'd2
  } event_t;

  typedef struct packed {
    logic [PeriodW-1:0] header_center;
    logic [TolW-1:0]    header_tolerance;
    logic [PeriodW-1:0] bit_threshold;
    logic [PeriodW-1:0] repeat_min;
    logic [PeriodW-1:0] repeat_max;
  } cfg_t;

  typedef struct packed {
    event_t           kind;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] command;
  } result_t;

endpackage

// File: hw/rtl/necir_regs.sv
// APB register file holding the decoder's timing windows.
module necir_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [necir_pkg::AddrW-1:0]   paddr,
  input  logic [necir_pkg::DataW-1:0]   pwdata,
  output logic [necir_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output necir_pkg::cfg_t               cfg
);

  necir_pkg::cfg_t cfg_r;
  necir_pkg::reg_idx_t idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = necir_pkg::reg_idx_t'(paddr[necir_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_center    <= necir_pkg::HeaderCenterRst;
      cfg_r.header_tolerance <= necir_pkg::HeaderTolRst;
      cfg_r.bit_threshold    <= necir_pkg::BitThreshRst;
      cfg_r.repeat_min       <= necir_pkg::RepeatMinRst;
      cfg_r.repeat_max       <= necir_pkg::RepeatMaxRst;
    end else if (wr_en) begin
      case (idx)
        necir_pkg::REG_HEADER_CENTER:
          cfg_r.header_center <= pwdata[necir_pkg::PeriodW-1:0];
        necir_pkg::REG_HEADER_TOL:
          cfg_r.header_tolerance <= pwdata[necir_pkg::TolW-1:0];
        necir_pkg::REG_BIT_THRESH:
          cfg_r.bit_threshold <= pwdata[necir_pkg::PeriodW-1:0];
        necir_pkg::REG_REPEAT_MIN:
          cfg_r.repeat_min <= pwdata[necir_pkg::PeriodW-1:0];
        necir_pkg::REG_REPEAT_MAX:
          cfg_r.repeat_max <= pwdata[necir_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      necir_pkg::REG_HEADER_CENTER:
        prdata = {{(necir_pkg::DataW-necir_pkg::PeriodW){1'b0}}, cfg_r.header_center};
      necir_pkg::REG_HEADER_TOL:
        prdata = {{(necir_pkg::DataW-necir_pkg::TolW){1'b0}}, cfg_r.header_tolerance};
      necir_pkg::REG_BIT_THRESH:
        prdata = {{(necir_pkg::DataW-necir_pkg::PeriodW){1'b0}}, cfg_r.bit_threshold};
      necir_pkg::REG_REPEAT_MIN:
        prdata = {{(necir_pkg::DataW-necir_pkg::PeriodW){1'b0}}, cfg_r.repeat_min};
      necir_pkg::REG_REPEAT_MAX:
        prdata = {{(necir_pkg::DataW-necir_pkg::PeriodW){1'b0}}, cfg_r.repeat_max};
      default: prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/necir_core.sv
// Frame decode state machine: header hunt, bit collection, check, repeat.
module necir_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [necir_pkg::PeriodW-1:0]  period,
  input  necir_pkg::cfg_t                cfg,
  output logic                           res_valid,
  output necir_pkg::result_t             res
);

  localparam int unsigned SumW = necir_pkg::PeriodW + 1;

  necir_pkg::phase_t phase_r, phase_nxt;
  logic [necir_pkg::CountW-1:0]    count_r, count_nxt;
  logic [necir_pkg::FrameBits-1:0] bits_r, bits_nxt;
  logic [necir_pkg::ByteW-1:0]     last_addr_r, last_addr_nxt;
  logic [necir_pkg::ByteW-1:0]     last_cmd_r, last_cmd_nxt;

  logic [SumW-1:0] p_plus_tol, c_plus_tol;
  logic hdr_hit, rpt_hit, bit_val, last_bit, chk_ok;
  logic [necir_pkg::FrameBits-1:0] shifted;
  logic [necir_pkg::ByteW-1:0] f_addr, f_naddr, f_cmd, f_ncmd;

  // Header window without wrap: center - tol < p  <=>  p + tol > center.
  assign p_plus_tol = SumW'(period) + SumW'(cfg.header_tolerance);
  assign c_plus_tol = SumW'(cfg.header_center) + SumW'(cfg.header_tolerance);
  assign hdr_hit    = (p_plus_tol > SumW'(cfg.header_center)) &&
                      (SumW'(period) < c_plus_tol);
  assign rpt_hit    = (period > cfg.repeat_min) && (period < cfg.repeat_max);
  assign bit_val    = period > cfg.bit_threshold;
  assign last_bit   = count_r == necir_pkg::CountW'(necir_pkg::FrameBits - 1);

  // Shift in at the top so the first bit lands in bit 0 after a full frame.
  assign shifted = {bit_val, bits_r[necir_pkg::FrameBits-1:1]};
  assign f_addr  = shifted[7:0];
  assign f_naddr = shifted[15:8];
  assign f_cmd   = shifted[23:16];
  assign f_ncmd  = shifted[31:24];
  assign chk_ok  = (f_addr == ~f_naddr) && (f_cmd == ~f_ncmd);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      necir_pkg::PH_BITS: begin
        if (last_bit) begin
          phase_nxt = chk_ok ? necir_pkg::PH_GOOD : necir_pkg::PH_HUNT;
        end
      end
      necir_pkg::PH_GOOD: begin
        if (!rpt_hit) begin
          phase_nxt = hdr_hit ? necir_pkg::PH_BITS : necir_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = hdr_hit ? necir_pkg::PH_BITS : necir_pkg::PH_HUNT;
      end
    endcase
  end

  // Datapath and result
  always_comb begin
    count_nxt     = count_r;
    bits_nxt      = bits_r;
    last_addr_nxt = last_addr_r;
    last_cmd_nxt  = last_cmd_r;
    res_valid     = 1'b0;
    res.kind      = necir_pkg::EV_FRAME;
    res.address   = '0;
    res.command   = '0;
    case (phase_r)
      necir_pkg::PH_BITS: begin
        count_nxt = count_r + 1'b1;
        bits_nxt  = shifted;
        if (last_bit) begin
          res_valid = 1'b1;
          if (chk_ok) begin
            last_addr_nxt = f_addr;
            last_cmd_nxt  = f_cmd;
            res.address   = f_addr;
            res.command   = f_cmd;
          end else begin
            res.kind = necir_pkg::EV_ERROR;
          end
        end
      end
      necir_pkg::PH_GOOD: begin
        if (rpt_hit) begin
          res_valid   = 1'b1;
          res.kind    = necir_pkg::EV_REPEAT;
          res.address = last_addr_r;
          res.command = last_cmd_r;
        end else if (hdr_hit) begin
          count_nxt = '0;
          bits_nxt  = '0;
        end
      end
      default: begin
        if (hdr_hit) begin
          count_nxt = '0;
          bits_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= necir_pkg::PH_HUNT;
      count_r     <= '0;
      bits_r      <= '0;
      last_addr_r <= '0;
      last_cmd_r  <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      bits_r      <= bits_nxt;
      last_addr_r <= last_addr_nxt;
      last_cmd_r  <= last_cmd_nxt;
    end
  end

endmodule

// File: hw/rtl/necir_out_buf.sv
// Result register with a skid stage between decoder and output channel.
module necir_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  necir_pkg::result_t  wr_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output necir_pkg::result_t  out_data
);

  logic               main_vld_r, skid_vld_r;
  necir_pkg::result_t main_r, skid_r;
  logic               pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        // no writes while skid is full; drain it into main on pop
        if (pop) begin
          skid_vld_r <= 1'b0;
        end
      end else if (wr_en) begin
        if (main_vld_r && !pop) begin
          skid_vld_r <= 1'b1;
        end else begin
          main_vld_r <= 1'b1;
        end
      end else if (pop) begin
        main_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (wr_en) begin
      if (main_vld_r && !pop) begin
        skid_r <= wr_data;
      end else begin
        main_r <= wr_data;
      end
    end
  end

endmodule

// File: hw/rtl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder.
//
// Input channel: one beat per measured falling-to-falling period (in_period_us,
// microseconds), taken when in_valid is high and in_stall is low.
// Output channel: one beat per decoded event (out_event_kind: new frame,
// repeat of last frame, complement check error; plus out_address and
// out_command), delivered when out_valid is high and out_stall is low.
// Most periods produce no beat; the 32nd data bit of a frame and a period in
// the repeat window after a good frame produce exactly one.
// Throughput: one period per clock cycle while in_stall is low. The decode is
// a single pass of compare and shift logic between the state registers and the
// result register, so each result is registered before it reaches the output.
// The result register is backed by a one-entry skid stage: input keeps
// flowing while a result waits; in_stall rises only when both hold a
// result, and drops at the same edge at which the receiver takes one.
// Configuration: APB port, registers at byte offsets 0x00 header center,
// 0x04 header tolerance, 0x08 bit threshold, 0x0C repeat min, 0x10 repeat
// max; write only while idle. pready is tied high.
// Reset (rst_n low, synchronous): timing registers return to their nominal
// NEC values, decoding returns to header hunt, buffered results are dropped.
module nec_ir_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [necir_pkg::PeriodW-1:0] in_period_us,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [necir_pkg::ByteW-1:0]   out_address,
  output logic [necir_pkg::ByteW-1:0]   out_command,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [necir_pkg::AddrW-1:0]   paddr,
  input  logic [necir_pkg::DataW-1:0]   pwdata,
  output logic [necir_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  necir_pkg::cfg_t    cfg;
  necir_pkg::result_t res, out_res;
  logic               res_valid;
  logic               buf_full;
  logic               accept;

  // Take a beat whenever the skid stage has room.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  necir_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  necir_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .period    (in_period_us),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Push a result only for an accepted beat that produced one.
  necir_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept && res_valid),
    .wr_data   (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_event_kind = out_res.kind;
  assign out_address    = out_res.address;
  assign out_command    = out_res.command;

endmodule

// File: bench/nec_ir_frame_decoder_tb.sv
// Self-checking testbench for the NEC infrared frame decoder.
module nec_ir_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off below.
  localparam int StallLimit = 4000;
  localparam int HoldOffCycles = 300;
  localparam int MaxReports = 50;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [necir_pkg::PeriodW-1:0]  in_period_us = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     out_event_kind;
  logic [necir_pkg::ByteW-1:0]    out_address;
  logic [necir_pkg::ByteW-1:0]    out_command;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [necir_pkg::AddrW-1:0]    paddr = '0;
  logic [necir_pkg::DataW-1:0]    pwdata = '0;
  logic [necir_pkg::DataW-1:0]    prdata;
  logic                           pready;

  // Shadow of the timing registers, tracked through every APB write.
  necir_pkg::cfg_t timing = '{header_center: necir_pkg::HeaderCenterRst,
                              header_tolerance: necir_pkg::HeaderTolRst,
                              bit_threshold: necir_pkg::BitThreshRst,
                              repeat_min: necir_pkg::RepeatMinRst,
                              repeat_max: necir_pkg::RepeatMaxRst};

  // Decoder state as the block should hold it.
  necir_pkg::phase_t           trk_phase = necir_pkg::PH_HUNT;
  logic [5:0]                  trk_count = '0;
  logic [31:0]                 trk_word = '0;
  logic [necir_pkg::ByteW-1:0] held_addr = '0;
  logic [necir_pkg::ByteW-1:0] held_cmd = '0;

  necir_pkg::result_t expected_events[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int kind_count[3] = '{0, 0, 0};
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  nec_ir_frame_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_period_us   (in_period_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_address    (out_address),
    .out_command    (out_command),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Print one mismatch line (capped) and count it.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Advance the expected decoder state by one accepted period and queue the
  // event it causes, if any.
  function automatic void decode_period(input logic [necir_pkg::PeriodW-1:0] p);
    necir_pkg::result_t ev;
    int      lo;
    int      hi;
    logic    hdr_hit;
    logic    rep_hit;
    // The header bounds are signed: a tolerance above the center admits
    // every short period instead of wrapping.
    lo = int'(timing.header_center) - int'(timing.header_tolerance);
    hi = int'(timing.header_center) + int'(timing.header_tolerance);
    hdr_hit = (int'(p) > lo) && (int'(p) < hi);
    rep_hit = (p > timing.repeat_min) && (p < timing.repeat_max);
    if (trk_phase == necir_pkg::PH_BITS) begin
      // Every period counts as a data bit here, header-like or not.
      trk_word[trk_count[4:0]] = (p > timing.bit_threshold);
      trk_count = trk_count + 6'd1;
      if (trk_count >= necir_pkg::FrameBits) begin
        trk_count = '0;
        if (trk_word[7:0] == ~trk_word[15:8] && trk_word[23:16] == ~trk_word[31:24]) begin
          held_addr = trk_word[7:0];
          held_cmd = trk_word[23:16];
          trk_phase = necir_pkg::PH_GOOD;
          ev.kind = necir_pkg::EV_FRAME;
          ev.address = held_addr;
          ev.command = held_cmd;
        end else begin
          // Check error: zero payload, last good frame is kept.
          trk_phase = necir_pkg::PH_HUNT;
          ev.kind = necir_pkg::EV_ERROR;
          ev.address = '0;
          ev.command = '0;
        end
        expected_events.push_back(ev);
      end
    end else if (trk_phase == necir_pkg::PH_GOOD && rep_hit) begin
      // Repeat window wins over an overlapping header window.
      ev.kind = necir_pkg::EV_REPEAT;
      ev.address = held_addr;
      ev.command = held_cmd;
      expected_events.push_back(ev);
    end else if (hdr_hit) begin
      trk_phase = necir_pkg::PH_BITS;
      trk_count = '0;
      trk_word = '0;
    end else begin
      trk_phase = necir_pkg::PH_HUNT;
    end
  endfunction

  // Pick a period inside the current header window, edges often.
  function automatic logic [necir_pkg::PeriodW-1:0] header_period();
    int lo;
    int hi;
    lo = int'(timing.header_center) - int'(timing.header_tolerance) + 1;
    hi = int'(timing.header_center) + int'(timing.header_tolerance) - 1;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (lo > hi) return timing.header_center;  // empty window
    case ($urandom_range(3))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // Pick a period inside the repeat window, or its lower edge if empty.
  function automatic logic [necir_pkg::PeriodW-1:0] repeat_period();
    int lo;
    int hi;
    lo = int'(timing.repeat_min) + 1;
    hi = int'(timing.repeat_max) - 1;
    if (lo > hi) return timing.repeat_min;
    case ($urandom_range(3))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // Pick a period that decodes as the given bit: threshold edges, field
  // extremes and header-looking periods mixed into ordinary ones.
  function automatic logic [necir_pkg::PeriodW-1:0] bit_period(input logic one);
    logic [necir_pkg::PeriodW-1:0] thr;
    logic [necir_pkg::PeriodW-1:0] hp;
    thr = timing.bit_threshold;
    hp = header_period();
    if (one && thr == 16'hFFFF) return 16'hFFFF;  // no period can be a one
    case ($urandom_range(7))
      0, 1: return one ? thr + 16'd1 : thr;
      2: return one ? 16'hFFFF : 16'd0;
      3: if ((hp > thr) == one) return hp;
      default: ;
    endcase
    return one ? 16'($urandom_range(65535, thr + 16'd1)) : 16'($urandom_range(thr, 0));
  endfunction

  // Offer one period beat, idling first at random; hold it until taken.
  task automatic send_period(input logic [necir_pkg::PeriodW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_period_us <= 16'($urandom());
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_period_us <= p;
    do @(posedge clk); while (in_stall);
    decode_period(p);
    items_sent++;
  endtask

  // Send a header and 32 data bits, LSB first; flips corrupt chosen bits.
  task automatic send_frame(input logic [necir_pkg::PeriodW-1:0] hdr, input logic [7:0] addr,
                            input logic [7:0] cmd, input logic [31:0] flips);
    logic [31:0] word;
    int          i;
    word = {~cmd, cmd, ~addr, addr} ^ flips;
    send_period(hdr);
    for (i = 0; i < 32; i++) begin
      send_period(bit_period(word[i]));
    end
  endtask

  // Drop valid and let the block drain before touching registers.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg(input necir_pkg::reg_idx_t idx);
    logic [necir_pkg::DataW-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      necir_pkg::REG_HEADER_CENTER: want = 32'(timing.header_center);
      necir_pkg::REG_HEADER_TOL:    want = 32'(timing.header_tolerance);
      necir_pkg::REG_BIT_THRESH:    want = 32'(timing.bit_threshold);
      necir_pkg::REG_REPEAT_MIN:    want = 32'(timing.repeat_min);
      necir_pkg::REG_REPEAT_MAX:    want = 32'(timing.repeat_max);
      default:                      want = '0;
    endcase
    if (prdata !== want) begin
      report_mismatch($sformatf("register %s reads %0h want %0h", idx.name(), prdata, want));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register with junk above its width, then read it back.
  task automatic write_reg(input necir_pkg::reg_idx_t idx,
                           input logic [necir_pkg::DataW-1:0] value);
    logic [necir_pkg::DataW-1:0] wr;
    wr = value | ($urandom() & 32'hFFFF_0000);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      necir_pkg::REG_HEADER_CENTER: timing.header_center = wr[15:0];
      necir_pkg::REG_HEADER_TOL:    timing.header_tolerance = wr[11:0];
      necir_pkg::REG_BIT_THRESH:    timing.bit_threshold = wr[15:0];
      necir_pkg::REG_REPEAT_MIN:    timing.repeat_min = wr[15:0];
      necir_pkg::REG_REPEAT_MAX:    timing.repeat_max = wr[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_reg(idx);
  endtask

  // Mostly well-formed frames (some corrupted) followed by repeats, the rest
  // loose repeats, headers and noise.
  task automatic run_mix(input int n);
    int stop_at;
    int pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(header_period(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   ($urandom_range(4) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0);
        repeat ($urandom_range(3)) send_period(repeat_period());
      end else if (pick < 75) begin
        send_period(repeat_period());
      end else if (pick < 85) begin
        send_period(header_period());
      end else begin
        send_period(16'($urandom()));
      end
    end
  endtask

  // Registers must come out of reset at their nominal values.
  task automatic test_reset_registers();
    necir_pkg::reg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      read_reg(idx);
      idx = idx.next();
    end
  endtask

  // Window edges, field extremes, repeats and restarts at reset timing.
  task automatic test_directed_frames();
    send_period(16'd0);
    send_period(16'hFFFF);
    send_period(16'd13000);                     // header lower edge, excluded
    send_period(16'd14000);                     // header upper edge, excluded
    send_frame(16'd13001, 8'h00, 8'hFF, 32'd0);
    send_period(16'd12501);                     // repeat, lowest
    send_period(16'd12999);                     // repeat, highest
    send_period(16'd12500);                     // repeat edge: back to hunting
    send_period(16'd12700);                     // repeat while hunting: ignored
    send_frame(16'd13999, 8'h5A, 8'hC3, 32'h0100_0000);  // bad inverted command
    send_period(16'd12700);                     // no repeat after a check error
    send_frame(16'd13500, 8'hFF, 8'h00, 32'd0);
    send_frame(16'd13500, 8'h3C, 8'hA5, 32'd0);  // header after a good frame restarts
    send_period(16'd13000);                     // neither window: hunt
    send_period(16'd12800);
  endtask

  // Header window reaching below zero, every nonzero period a one, and a
  // repeat window overlapping the header window.
  task automatic test_wide_windows();
    quiesce();
    write_reg(necir_pkg::REG_HEADER_CENTER, 32'd0);
    write_reg(necir_pkg::REG_HEADER_TOL, 32'd4095);
    write_reg(necir_pkg::REG_BIT_THRESH, 32'd0);
    write_reg(necir_pkg::REG_REPEAT_MIN, 32'd0);
    write_reg(necir_pkg::REG_REPEAT_MAX, 32'd65535);
    run_mix(120);
  endtask

  // Header at the top of the range, no ones possible, empty repeat window,
  // then an empty header window as well.
  task automatic test_narrow_windows();
    quiesce();
    write_reg(necir_pkg::REG_HEADER_CENTER, 32'd65535);
    write_reg(necir_pkg::REG_HEADER_TOL, 32'd4095);
    write_reg(necir_pkg::REG_BIT_THRESH, 32'd65535);
    write_reg(necir_pkg::REG_REPEAT_MIN, 32'd65535);
    write_reg(necir_pkg::REG_REPEAT_MAX, 32'd0);
    run_mix(60);
    quiesce();
    write_reg(necir_pkg::REG_HEADER_TOL, 32'd0);
    run_mix(30);
  endtask

  // Random timing set, then a mixed stream under it.
  task automatic test_random_traffic(input int n);
    logic [necir_pkg::DataW-1:0] rmin;
    quiesce();
    write_reg(necir_pkg::REG_HEADER_CENTER, $urandom());
    write_reg(necir_pkg::REG_HEADER_TOL, $urandom());
    write_reg(necir_pkg::REG_BIT_THRESH, $urandom());
    rmin = $urandom();
    write_reg(necir_pkg::REG_REPEAT_MIN, rmin);
    write_reg(necir_pkg::REG_REPEAT_MAX,
              $urandom_range(1) ? rmin + $urandom_range(4000) : $urandom());
    run_mix(n);
  endtask

  // Hold the receiver off while repeats keep coming, so the result and skid
  // registers fill and the block stalls its input.
  task automatic test_backpressure();
    quiesce();
    write_reg(necir_pkg::REG_HEADER_CENTER, 32'(necir_pkg::HeaderCenterRst));
    write_reg(necir_pkg::REG_HEADER_TOL, 32'(necir_pkg::HeaderTolRst));
    write_reg(necir_pkg::REG_BIT_THRESH, 32'(necir_pkg::BitThreshRst));
    write_reg(necir_pkg::REG_REPEAT_MIN, 32'(necir_pkg::RepeatMinRst));
    write_reg(necir_pkg::REG_REPEAT_MAX, 32'(necir_pkg::RepeatMaxRst));
    send_frame(header_period(), 8'($urandom_range(255)), 8'($urandom_range(255)), 32'd0);
    hold_left = HoldOffCycles;
    repeat (40) send_period(repeat_period());
  endtask

  // Receiver: stall at random, or hold off for a counted stretch.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each delivered event beat with the oldest expectation.
  always @(posedge clk) begin : event_check
    necir_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("event beat with none expected: kind %0d addr %02h cmd %02h",
                                  out_event_kind, out_address, out_command));
      end else begin
        want = expected_events.pop_front();
        kind_count[want.kind]++;
        if (out_event_kind !== want.kind) begin
          report_mismatch($sformatf("event_kind %0d want %0d", out_event_kind, want.kind));
        end
        if (out_address !== want.address) begin
          report_mismatch($sformatf("address %02h want %02h", out_address, want.address));
        end
        if (out_command !== want.command) begin
          report_mismatch($sformatf("command %02h want %02h", out_command, want.command));
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TIMEOUT: no beat accepted for %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 11;
    recv_idle_pct = 74;
    test_reset_registers();
    test_directed_frames();
    test_wide_windows();
    test_narrow_windows();
    test_random_traffic(200);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 74;
    recv_idle_pct = 11;
    test_random_traffic(200);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(200);

    // Drain: let every expected event arrive, then a few more cycles.
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Coverage: %0d periods over reset, extreme and random timing, incl. a long hold-off",
             items_sent);
    $display("Events: %0d frames, %0d repeats, %0d check errors; %0d mismatches",
             kind_count[necir_pkg::EV_FRAME], kind_count[necir_pkg::EV_REPEAT],
             kind_count[necir_pkg::EV_ERROR], mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
